// ===== rtl/core/lps_pkg.sv =====
// Package: word types, constants and the arctangent table for the lookahead point selector.
package lps_pkg;

  localparam int unsigned PosW   = 24;
  localparam int unsigned QuatW  = 16;
  localparam int unsigned LenW   = 23;
  localparam int unsigned HeadW  = 16;
  localparam int unsigned OpW    = 25;  // multiplier operand width
  localparam int unsigned ProdW  = 50;
  localparam int unsigned AccW   = 51;
  localparam int unsigned ArgW   = 34;  // CORDIC argument width
  localparam int unsigned AngW   = 34;  // Q4.30 angle accumulator
  localparam int unsigned TableLen = 24;

  localparam logic signed [AngW-1:0]  HalfPiQ30  = 34'sd1686629713;
  localparam logic signed [HeadW-1:0] HeadingMax = 16'sd25736;
  localparam logic [LenW-1:0]         LookaheadReset = 23'd4096;

  typedef struct packed {
    logic                    cmd;
    logic signed [PosW-1:0]  pos_x;
    logic signed [PosW-1:0]  pos_y;
    logic signed [QuatW-1:0] quat_x;
    logic signed [QuatW-1:0] quat_y;
    logic signed [QuatW-1:0] quat_z;
    logic signed [QuatW-1:0] quat_w;
    logic                    final_point;
  } in_word_t;

  typedef struct packed {
    logic signed [PosW-1:0]  target_x;
    logic signed [PosW-1:0]  target_y;
    logic signed [HeadW-1:0] heading;
    logic                    heading_source;
  } out_word_t;

  typedef struct packed {
    logic clear;
    logic mul_en;
    logic acc_en;
    logic acc_sel_b;
    logic acc_sub;
  } mac_ctrl_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_EVAL,
    ST_CORDIC,
    ST_EMIT
  } state_e;

  typedef enum logic [1:0] {
    MODE_DIST,
    MODE_YAW,
    MODE_PEND
  } mode_e;

  // atan(2^-i) in Q4.30
  function automatic logic signed [AngW-1:0] atan_q30(input logic [4:0] idx);
    logic signed [AngW-1:0] v;
    case (idx)
      5'd0:  v = 34'sh03243F6A8;
      5'd1:  v = 34'sh01DAC6705;
      5'd2:  v = 34'sh00FADBAFC;
      5'd3:  v = 34'sh007F56EA6;
      5'd4:  v = 34'sh003FEAB76;
      5'd5:  v = 34'sh001FFD55B;
      5'd6:  v = 34'sh000FFFAAA;
      5'd7:  v = 34'sh0007FFF55;
      5'd8:  v = 34'sh0003FFFEA;
      5'd9:  v = 34'sh0001FFFFD;
      5'd10: v = 34'sh0000FFFFF;
      5'd11: v = 34'sh00007FFFF;
      5'd12: v = 34'sh00003FFFF;
      5'd13: v = 34'sh00001FFFF;
      5'd14: v = 34'sh00000FFFF;
      5'd15: v = 34'sh000007FFF;
      5'd16: v = 34'sh000003FFF;
      5'd17: v = 34'sh000001FFF;
      5'd18: v = 34'sh000000FFF;
      5'd19: v = 34'sh0000007FF;
      5'd20: v = 34'sh0000003FF;
      5'd21: v = 34'sh0000001FF;
      5'd22: v = 34'sh0000000FF;
      5'd23: v = 34'sh00000007F;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/core/lps_mac.sv =====
// Shared 25x25 multiplier with two accumulators, used for distance and yaw sums.
module lps_mac (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  lps_pkg::mac_ctrl_t                  ctrl_i,
  input  logic signed [lps_pkg::OpW-1:0]      op_a_i,
  input  logic signed [lps_pkg::OpW-1:0]      op_b_i,
  output logic signed [lps_pkg::AccW-1:0]     acc_a_o,
  output logic signed [lps_pkg::AccW-1:0]     acc_b_o
);

  logic signed [lps_pkg::ProdW-1:0] prod_q;
  logic signed [lps_pkg::AccW-1:0]  acc_a_q, acc_a_d, acc_b_q, acc_b_d, prod_ext;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.mul_en) begin
      prod_q <= op_a_i * op_b_i;
    end
  end

  always_comb begin
    prod_ext = {prod_q[lps_pkg::ProdW-1], prod_q};
    acc_a_d  = acc_a_q;
    acc_b_d  = acc_b_q;
    if (ctrl_i.clear) begin
      acc_a_d = '0;
      acc_b_d = '0;
    end else if (ctrl_i.acc_en) begin
      if (ctrl_i.acc_sel_b) begin
        acc_b_d = ctrl_i.acc_sub ? acc_b_q - prod_ext : acc_b_q + prod_ext;
      end else begin
        acc_a_d = ctrl_i.acc_sub ? acc_a_q - prod_ext : acc_a_q + prod_ext;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_a_q <= '0;
      acc_b_q <= '0;
    end else begin
      acc_a_q <= acc_a_d;
      acc_b_q <= acc_b_d;
    end
  end

  assign acc_a_o = acc_a_q;
  assign acc_b_o = acc_b_q;

endmodule

// ===== rtl/core/lps_cordic.sv =====
// Iterative vectoring CORDIC: atan2 of a pair, one rotation per cycle, Q3.13 result.
module lps_cordic #(
  parameter int unsigned ITERS = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start_i,
  input  logic signed [lps_pkg::ArgW-1:0]      y_i,
  input  logic signed [lps_pkg::ArgW-1:0]      x_i,
  output logic                                 done_o,
  output logic signed [lps_pkg::HeadW-1:0]     heading_o
);

  localparam int unsigned CW   = 58;
  localparam int unsigned EW   = lps_pkg::ArgW + 2;
  localparam int unsigned IW   = (ITERS > 1) ? $clog2(ITERS) : 1;
  localparam logic [IW-1:0] Last = IW'(ITERS - 1);

  logic signed [CW-1:0]   x_q, y_q, xs, ys;
  logic signed [lps_pkg::AngW-1:0] z_q, zr;
  logic [IW-1:0]          it_q;
  logic                   active_q, done_q, zero_q;
  logic signed [EW-1:0]   xe, ye, x0, y0;
  logic signed [lps_pkg::AngW-1:0] z0;

  // quadrant fold so the vector starts in the right half plane
  always_comb begin
    xe = EW'(x_i);
    ye = EW'(y_i);
    x0 = xe;
    y0 = ye;
    z0 = '0;
    if (x_i < 0) begin
      if (y_i >= 0) begin
        x0 = ye;
        y0 = -xe;
        z0 = lps_pkg::HalfPiQ30;
      end else begin
        x0 = -ye;
        y0 = xe;
        z0 = -lps_pkg::HalfPiQ30;
      end
    end
  end

  assign xs = x_q >>> it_q;
  assign ys = y_q >>> it_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      done_q   <= 1'b0;
      it_q     <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        active_q <= 1'b1;
        it_q     <= '0;
      end else if (active_q) begin
        if (it_q == Last) begin
          active_q <= 1'b0;
          done_q   <= 1'b1;
        end else begin
          it_q <= it_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q    <= {{(CW-EW-20){x0[EW-1]}}, x0, 20'b0};
      y_q    <= {{(CW-EW-20){y0[EW-1]}}, y0, 20'b0};
      z_q    <= z0;
      zero_q <= (x_i == '0) && (y_i == '0);
    end else if (active_q) begin
      if (y_q > 0) begin
        x_q <= x_q + ys;
        y_q <= y_q - xs;
        z_q <= z_q + lps_pkg::atan_q30(5'(it_q));
      end else begin
        x_q <= x_q - ys;
        y_q <= y_q + xs;
        z_q <= z_q - lps_pkg::atan_q30(5'(it_q));
      end
    end
  end

  // round half up from Q4.30 to Q3.13, then clamp
  always_comb begin
    zr = (z_q + 34'sd65536) >>> 17;
    if (zero_q) begin
      heading_o = '0;
    end else if (zr > lps_pkg::AngW'(lps_pkg::HeadingMax)) begin
      heading_o = lps_pkg::HeadingMax;
    end else if (zr < -lps_pkg::AngW'(lps_pkg::HeadingMax)) begin
      heading_o = -lps_pkg::HeadingMax;
    end else begin
      heading_o = zr[lps_pkg::HeadW-1:0];
    end
  end

  assign done_o = done_q;

endmodule

// ===== rtl/core/lookahead_point_select_core.sv =====
// Lookahead point selector: sequencer, state registers and output stage around the shared units.
// A start word (cmd 0) latches the robot position. A path point is tested against the lookahead
// radius with one shared 25x25 multiplier: three products, a final accumulate step and the
// compare. A point that closes the path runs an atan2 on the iterative CORDIC, one rotation per
// cycle: the final point first forms its yaw terms with six products; the point after a held
// target goes straight to the CORDIC. The input is not ready while a word is in work; a
// result sits in the output register until taken, and the next word is accepted meanwhile,
// though a further result waits in the block, input held off, until the register is free.
module lookahead_point_select_core #(
  parameter int unsigned CORDIC_ITERATIONS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  lps_pkg::in_word_t             in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output lps_pkg::out_word_t            out_data_o,
  input  logic                          cfg_we_i,
  input  logic [lps_pkg::LenW-1:0]      cfg_wdata_i
);

  localparam int unsigned Iters = (CORDIC_ITERATIONS > lps_pkg::TableLen) ?
                                  lps_pkg::TableLen : CORDIC_ITERATIONS;
  localparam int unsigned PW = lps_pkg::PosW;
  localparam int unsigned DW = PW + 1;

  lps_pkg::state_e state_q, state_d;
  lps_pkg::mode_e  mode_q, mode_d;

  logic [lps_pkg::LenW-1:0] look_q;
  logic signed [PW-1:0] robot_x_q, robot_y_q, held_x_q, held_y_q;
  logic signed [PW-1:0] pos_x_q, pos_y_q, tgt_x_q, tgt_y_q;
  logic signed [DW-1:0] dx_q, dy_q;
  logic signed [lps_pkg::QuatW-1:0] qx_q, qy_q, qz_q, qw_q;
  logic pending_q, done_q;
  logic [2:0] step_q;
  logic src_q;
  logic signed [lps_pkg::HeadW-1:0] head_q;

  logic out_valid_q;
  lps_pkg::out_word_t out_q;

  logic accept, emit, cstart, cdone, hold_pt;
  logic [2:0] nsteps, pair;
  lps_pkg::mac_ctrl_t ctrl;
  logic signed [lps_pkg::OpW-1:0] op_a, op_b;
  logic signed [lps_pkg::AccW-1:0] acc_a, acc_b;
  logic signed [lps_pkg::ArgW-1:0] cy, cx;
  logic signed [lps_pkg::HeadW-1:0] cheading;
  logic signed [PW-1:0] base_x, base_y;

  assign in_ready_o = (state_q == lps_pkg::ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  function automatic logic signed [lps_pkg::OpW-1:0] q_ext(
      input logic signed [lps_pkg::QuatW-1:0] q);
    return {{(lps_pkg::OpW-lps_pkg::QuatW){q[lps_pkg::QuatW-1]}}, q};
  endfunction

  assign base_x = pending_q ? held_x_q : robot_x_q;
  assign base_y = pending_q ? held_y_q : robot_y_q;

  assign nsteps = (mode_q == lps_pkg::MODE_YAW) ? 3'd6 : 3'd3;
  assign pair   = step_q - 3'd1;

  // operand pairs: distance dx*dx, dy*dy, L*L; yaw w*z, x*y, w*w, x*x, y*y, z*z
  always_comb begin
    op_a = '0;
    op_b = '0;
    if (mode_q == lps_pkg::MODE_YAW) begin
      case (step_q)
        3'd0: begin op_a = q_ext(qw_q); op_b = q_ext(qz_q); end
        3'd1: begin op_a = q_ext(qx_q); op_b = q_ext(qy_q); end
        3'd2: begin op_a = q_ext(qw_q); op_b = q_ext(qw_q); end
        3'd3: begin op_a = q_ext(qx_q); op_b = q_ext(qx_q); end
        3'd4: begin op_a = q_ext(qy_q); op_b = q_ext(qy_q); end
        3'd5: begin op_a = q_ext(qz_q); op_b = q_ext(qz_q); end
        default: begin op_a = '0; op_b = '0; end
      endcase
    end else begin
      case (step_q)
        3'd0: begin op_a = dx_q; op_b = dx_q; end
        3'd1: begin op_a = dy_q; op_b = dy_q; end
        3'd2: begin
          op_a = $signed({2'b00, look_q});
          op_b = $signed({2'b00, look_q});
        end
        default: begin op_a = '0; op_b = '0; end
      endcase
    end
  end

  always_comb begin
    state_d = state_q;
    mode_d  = mode_q;
    ctrl    = '0;
    cstart  = 1'b0;
    emit    = 1'b0;
    hold_pt = 1'b0;
    cy      = '0;
    cx      = '0;
    case (state_q)
      lps_pkg::ST_IDLE: begin
        if (accept && in_data_i.cmd && !done_q) begin
          ctrl.clear = 1'b1;
          state_d    = pending_q ? lps_pkg::ST_EVAL : lps_pkg::ST_MUL;
          mode_d     = pending_q ? lps_pkg::MODE_PEND :
                       (in_data_i.final_point ? lps_pkg::MODE_YAW : lps_pkg::MODE_DIST);
        end
      end
      lps_pkg::ST_MUL: begin
        ctrl.mul_en    = (step_q < nsteps);
        ctrl.acc_en    = (step_q != 3'd0);
        ctrl.acc_sel_b = (pair >= 3'd2);
        ctrl.acc_sub   = (pair >= 3'd4);
        if (step_q == nsteps) begin
          state_d = lps_pkg::ST_EVAL;
        end
      end
      lps_pkg::ST_EVAL: begin
        case (mode_q)
          lps_pkg::MODE_DIST: begin
            hold_pt = (acc_a >= acc_b);
            state_d = lps_pkg::ST_IDLE;
          end
          lps_pkg::MODE_YAW: begin
            cy      = {acc_a[lps_pkg::ArgW-2:0], 1'b0};
            cx      = acc_b[lps_pkg::ArgW-1:0];
            cstart  = 1'b1;
            state_d = lps_pkg::ST_CORDIC;
          end
          default: begin
            cy      = lps_pkg::ArgW'(dy_q);
            cx      = lps_pkg::ArgW'(dx_q);
            cstart  = 1'b1;
            state_d = lps_pkg::ST_CORDIC;
          end
        endcase
      end
      lps_pkg::ST_CORDIC: begin
        if (cdone) begin
          state_d = lps_pkg::ST_EMIT;
        end
      end
      lps_pkg::ST_EMIT: begin
        if (!out_valid_q || out_ready_i) begin
          emit    = 1'b1;
          state_d = lps_pkg::ST_IDLE;
        end
      end
      default: state_d = lps_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lps_pkg::ST_IDLE;
      mode_q      <= lps_pkg::MODE_DIST;
      look_q      <= lps_pkg::LookaheadReset;
      robot_x_q   <= '0;
      robot_y_q   <= '0;
      held_x_q    <= '0;
      held_y_q    <= '0;
      pending_q   <= 1'b0;
      done_q      <= 1'b1;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      mode_q  <= mode_d;
      if (cfg_we_i) begin
        look_q <= cfg_wdata_i;
      end
      if (accept && !in_data_i.cmd) begin
        robot_x_q <= in_data_i.pos_x;
        robot_y_q <= in_data_i.pos_y;
        pending_q <= 1'b0;
        done_q    <= 1'b0;
      end else if (accept && !done_q) begin
        // a held target or the final point closes the path
        if (pending_q || in_data_i.final_point) begin
          pending_q <= 1'b0;
          done_q    <= 1'b1;
        end
      end else if (hold_pt) begin
        held_x_q  <= pos_x_q;
        held_y_q  <= pos_y_q;
        pending_q <= 1'b1;
      end
      if (state_q == lps_pkg::ST_MUL) begin
        step_q <= step_q + 3'd1;
      end else begin
        step_q <= '0;
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      pos_x_q <= in_data_i.pos_x;
      pos_y_q <= in_data_i.pos_y;
      dx_q    <= DW'(in_data_i.pos_x) - DW'(base_x);
      dy_q    <= DW'(in_data_i.pos_y) - DW'(base_y);
      qx_q    <= in_data_i.quat_x;
      qy_q    <= in_data_i.quat_y;
      qz_q    <= in_data_i.quat_z;
      qw_q    <= in_data_i.quat_w;
      tgt_x_q <= pending_q ? held_x_q : in_data_i.pos_x;
      tgt_y_q <= pending_q ? held_y_q : in_data_i.pos_y;
      src_q   <= !pending_q;
    end
    if (cdone) begin
      head_q <= cheading;
    end
    if (emit) begin
      out_q.target_x       <= tgt_x_q;
      out_q.target_y       <= tgt_y_q;
      out_q.heading        <= head_q;
      out_q.heading_source <= src_q;
    end
  end

  lps_mac u_mac (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (ctrl),
    .op_a_i  (op_a),
    .op_b_i  (op_b),
    .acc_a_o (acc_a),
    .acc_b_o (acc_b)
  );

  lps_cordic #(
    .ITERS (Iters)
  ) u_cordic (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (cstart),
    .y_i       (cy),
    .x_i       (cx),
    .done_o    (cdone),
    .heading_o (cheading)
  );

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
